@@ hdl/cfra_pkg.sv @@
// ----------------------------------------------------------------------------
// cfra_pkg
// Shared types, codes and sizes for the contiguous free-run allocator.
// ----------------------------------------------------------------------------
package cfra_pkg;

  localparam int unsigned SLOTS   = 1024;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BIT_W   = 5;
  localparam int unsigned WORDS   = SLOTS / WORD_W;
  localparam int unsigned WADDR_W = IDX_W - BIT_W;
  localparam int unsigned CNT_W   = WADDR_W + 1;

  localparam logic [1:0] FN_FIND = 2'd0;
  localparam logic [1:0] FN_USED = 2'd1;
  localparam logic [1:0] FN_FREE = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_INV   = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] range_start;
    logic [IDX_W-1:0] range_end;
    logic [LEN_W-1:0] run_length;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] position;
    logic [LEN_W-1:0] longest_free;
  } out_t;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_SCAN,
    FSM_FIN
  } fsm_e;

  typedef struct packed {
    logic load_item;
    logic cnt_inc;
    logic cnt_clr;
    logic clr_wr;
    logic scan;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic cnt_full;
    logic clr_last;
    logic scan_done;
  } sts_t;

endpackage

@@ hdl/cfra_ram.sv @@
// ----------------------------------------------------------------------------
// cfra_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cfra_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/cfra_datapath.sv @@
// ----------------------------------------------------------------------------
// cfra_datapath
// Occupancy bitmap store, word-wise mark and run scan, result register.
// ----------------------------------------------------------------------------
module cfra_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfra_pkg::in_t   in_data_i,
  input  cfra_pkg::cmd_t  cmd_i,
  output cfra_pkg::sts_t  sts_o,
  output cfra_pkg::out_t  out_data_o
);

  localparam int unsigned W     = cfra_pkg::WORD_W;
  localparam int unsigned BW    = cfra_pkg::BIT_W;
  localparam int unsigned LW    = cfra_pkg::LEN_W;
  localparam int unsigned IW    = cfra_pkg::IDX_W;
  localparam int unsigned AW    = cfra_pkg::WADDR_W;
  localparam int unsigned CW    = cfra_pkg::CNT_W;
  localparam int unsigned LVLS  = BW;

  cfra_pkg::in_t  item_q;
  cfra_pkg::out_t out_q, res;
  logic [CW-1:0]  cnt_q;
  logic           proc_v_q;
  logic [AW-1:0]  wrd_q;
  logic [LW-1:0]  cur_q, acc_q, longest_q;
  logic           found_q;
  logic [IW-1:0]  pos_q;

  logic [W-1:0]   rdata, mask, occ, wdata;
  logic [AW-1:0]  waddr;
  logic           we;
  logic           is_mark, is_find, in_mark, in_find;
  logic [W-1:0]   has_l  [LVLS+1];
  logic [BW-1:0]  last_l [LVLS+1][W];
  logic [LW-1:0]  run_end [W];
  logic [LW-1:0]  mx_l   [LVLS+1][W];
  logic           fit_any;
  logic [BW-1:0]  fit_idx;
  logic [LW-1:0]  pos_full, wmax;

  assign is_mark = (item_q.func == cfra_pkg::FN_USED) || (item_q.func == cfra_pkg::FN_FREE);
  assign is_find = (item_q.func == cfra_pkg::FN_FIND);
  assign in_mark = (in_data_i.func == cfra_pkg::FN_USED) ||
                   (in_data_i.func == cfra_pkg::FN_FREE);
  assign in_find = (in_data_i.func == cfra_pkg::FN_FIND);

  always_comb begin
    sts_o.need_scan = (in_mark && (in_data_i.range_start <= in_data_i.range_end)) ||
                      (in_find && (in_data_i.run_length != '0) &&
                       (in_data_i.run_length <= longest_q));
    sts_o.cnt_full  = (cnt_q == CW'(cfra_pkg::WORDS));
    sts_o.clr_last  = (cnt_q == CW'(cfra_pkg::WORDS - 1));
    sts_o.scan_done = sts_o.cnt_full && !proc_v_q;
  end

  // range mask and updated word
  always_comb begin
    for (int i = 0; i < W; i++) begin
      mask[i] = ((wrd_q > item_q.range_start[IW-1:BW]) ||
                 ((wrd_q == item_q.range_start[IW-1:BW]) &&
                  (BW'(i) >= item_q.range_start[BW-1:0]))) &&
                ((wrd_q < item_q.range_end[IW-1:BW]) ||
                 ((wrd_q == item_q.range_end[IW-1:BW]) &&
                  (BW'(i) <= item_q.range_end[BW-1:0])));
    end
    if (!is_mark) begin
      occ = rdata;
    end else if (item_q.func == cfra_pkg::FN_USED) begin
      occ = rdata | mask;
    end else begin
      occ = rdata & ~mask;
    end
  end

  // last occupied bit at or below each position, prefix tree
  always_comb begin
    has_l[0] = occ;
    for (int i = 0; i < W; i++) begin
      last_l[0][i] = BW'(i);
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < W; i++) begin
        if ((i >= (1 << l)) && !has_l[l][i]) begin
          has_l[l+1][i]  = has_l[l][i - (1 << l)];
          last_l[l+1][i] = last_l[l][i - (1 << l)];
        end else begin
          has_l[l+1][i]  = has_l[l][i];
          last_l[l+1][i] = last_l[l][i];
        end
      end
    end
    for (int i = 0; i < W; i++) begin
      if (occ[i]) begin
        run_end[i] = '0;
      end else if (has_l[LVLS][i]) begin
        run_end[i] = LW'(i) - LW'(last_l[LVLS][i]);
      end else begin
        run_end[i] = cur_q + LW'(i) + LW'(1);
      end
    end
  end

  // first fitting run end and word maximum
  always_comb begin
    fit_any = 1'b0;
    fit_idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (run_end[i] >= item_q.run_length) begin
        fit_any = 1'b1;
        fit_idx = BW'(i);
      end
    end
    pos_full = LW'({wrd_q, fit_idx}) + LW'(1) - item_q.run_length;
    for (int l = 0; l <= LVLS; l++) begin
      for (int i = 0; i < W; i++) begin
        mx_l[l][i] = '0;
      end
    end
    for (int i = 0; i < W; i++) begin
      mx_l[0][i] = run_end[i];
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < (W >> (l + 1)); i++) begin
        mx_l[l+1][i] = (mx_l[l][2*i] > mx_l[l][2*i+1]) ? mx_l[l][2*i] : mx_l[l][2*i+1];
      end
    end
    wmax = mx_l[LVLS][0];
  end

  assign we    = cmd_i.clr_wr || (proc_v_q && is_mark);
  assign waddr = cmd_i.clr_wr ? cnt_q[AW-1:0] : wrd_q;
  assign wdata = cmd_i.clr_wr ? '0 : occ;

  cfra_ram #(
    .WIDTH (W),
    .DEPTH (cfra_pkg::WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    res.status       = cfra_pkg::ST_DONE;
    res.position     = '0;
    res.longest_free = longest_q;
    if (is_mark) begin
      if (item_q.range_start > item_q.range_end) begin
        res.status = cfra_pkg::ST_INV;
      end else begin
        res.longest_free = acc_q;
      end
    end else if (is_find) begin
      if ((item_q.run_length != '0) && (item_q.run_length > longest_q)) begin
        res.status = cfra_pkg::ST_NOFIT;
      end else if (found_q) begin
        res.position = pos_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      proc_v_q  <= 1'b0;
      longest_q <= LW'(cfra_pkg::SLOTS);
    end else begin
      if (cmd_i.cnt_clr || cmd_i.load_item) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end
      proc_v_q <= cmd_i.scan && !sts_o.cnt_full;
      if (cmd_i.load_result) begin
        longest_q <= res.longest_free;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wrd_q <= cnt_q[AW-1:0];
    if (cmd_i.load_item) begin
      item_q  <= in_data_i;
      cur_q   <= '0;
      acc_q   <= '0;
      found_q <= 1'b0;
      pos_q   <= '0;
    end else if (proc_v_q) begin
      cur_q <= run_end[W-1];
      acc_q <= (wmax > acc_q) ? wmax : acc_q;
      if (is_find && !found_q && fit_any) begin
        found_q <= 1'b1;
        pos_q   <= pos_full[IW-1:0];
      end
    end
    if (cmd_i.load_result) begin
      out_q <= res;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ hdl/cfra_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfra_ctrl
// Sequencer: clearing pass, item intake, word scan, result hand-off.
// ----------------------------------------------------------------------------
module cfra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cfra_pkg::sts_t sts_i,
  output cfra_pkg::cmd_t cmd_o
);

  cfra_pkg::fsm_e state_q, state_d;
  logic           out_valid_q, out_valid_d;
  logic           out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfra_pkg::FSM_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cfra_pkg::FSM_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = cfra_pkg::FSM_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      cfra_pkg::FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = sts_i.need_scan ? cfra_pkg::FSM_SCAN : cfra_pkg::FSM_FIN;
        end
      end
      cfra_pkg::FSM_SCAN: begin
        cmd_o.scan    = 1'b1;
        cmd_o.cnt_inc = !sts_i.cnt_full;
        if (sts_i.scan_done) begin
          state_d = cfra_pkg::FSM_FIN;
        end
      end
      cfra_pkg::FSM_FIN: begin
        if (out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = cfra_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = cfra_pkg::FSM_CLEAR;
      end
    endcase
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/contiguous_free_run_allocator.sv @@
// ----------------------------------------------------------------------------
// contiguous_free_run_allocator
// Tracks 1024 slots; marks ranges occupied or free and finds first-fit runs.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i / in_ready_o, in_data_i): one request per
//   transaction: find first fit, mark range occupied, mark range free.
//   out channel (out_valid_o / out_ready_i, out_data_o): one response per
//   request with status, position and the longest free run afterwards.
// Occupancy is held as a 32 x 32-bit bitmap RAM; a valid mark or fitting find
// walks all 32 words, one word per cycle behind the registered RAM read.
// Walked requests pass IDLE, SCAN and FIN; requests settled without a walk
// (inverted range, no fit, zero length, unused code) pass IDLE and FIN only.
// One request at a time: a new request is taken only back in IDLE.
// Reset: a clearing pass writes all 32 words to zero, marking every slot free;
// in_ready_o stays low until it ends.
// Stall: the response sits in an output register; the next request is
// accepted meanwhile, and a second response waits until the first is taken.
// ----------------------------------------------------------------------------
module contiguous_free_run_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cfra_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cfra_pkg::out_t out_data_o
);

  cfra_pkg::cmd_t cmd;
  cfra_pkg::sts_t sts;

  cfra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cfra_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

@@ tb/sv/cfra_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfra_checker
// Watches both channels of the allocator, keeps its own model of the slot
// row, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module cfra_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  cfra_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  cfra_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             pending_o
);

  localparam int unsigned SLOTS = cfra_pkg::SLOTS;
  localparam int unsigned IDX_W = cfra_pkg::IDX_W;
  localparam int unsigned LEN_W = cfra_pkg::LEN_W;

  bit             slot_free [SLOTS];
  cfra_pkg::out_t resp_q [$];

  initial begin
    foreach (slot_free[i]) slot_free[i] = 1'b1;
    fail_count_o = 0;
  end

  assign pending_o = resp_q.size();

  function automatic int longest_run_now();
    int best, cur;
    best = 0;
    cur  = 0;
    for (int i = 0; i < SLOTS; i++) begin
      cur  = slot_free[i] ? cur + 1 : 0;
      best = (cur > best) ? cur : best;
    end
    return best;
  endfunction

  function automatic cfra_pkg::out_t apply_request(cfra_pkg::in_t req);
    cfra_pkg::out_t r;
    int             cur;
    r = '0;
    case (req.func)
      cfra_pkg::FN_FIND: begin
        if (req.run_length != 0) begin
          cur = 0;
          r.status = cfra_pkg::ST_NOFIT;
          for (int i = 0; i < SLOTS; i++) begin
            cur = slot_free[i] ? cur + 1 : 0;
            if (cur >= req.run_length) begin
              r.status   = cfra_pkg::ST_DONE;
              r.position = IDX_W'(i + 1 - cur);
              break;
            end
          end
        end
      end
      cfra_pkg::FN_USED, cfra_pkg::FN_FREE: begin
        if (req.range_start > req.range_end) r.status = cfra_pkg::ST_INV;
        else
          for (int i = req.range_start; i <= req.range_end; i++)
            slot_free[i] = (req.func == cfra_pkg::FN_FREE);
      end
      default: ;
    endcase
    r.longest_free = LEN_W'(longest_run_now());
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("cfra_checker: %s mismatch, got %0d want %0d", what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    cfra_pkg::out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) resp_q.push_back(apply_request(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (resp_q.size() == 0) begin
          report_mismatch("pending response", 0, 1);
        end else begin
          want = resp_q.pop_front();
          if (out_data_i.status != want.status)
            report_mismatch("status", out_data_i.status, want.status);
          if (out_data_i.position != want.position)
            report_mismatch("position", out_data_i.position, want.position);
          if (out_data_i.longest_free != want.longest_free)
            report_mismatch("longest_free", out_data_i.longest_free, want.longest_free);
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random allocator requests with random idling on both
// channels; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned SLOTS = cfra_pkg::SLOTS;
  localparam int unsigned IDX_W = cfra_pkg::IDX_W;
  localparam int unsigned LEN_W = cfra_pkg::LEN_W;

  logic           clk_i, rst_ni;
  logic           in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  cfra_pkg::in_t  in_data_i;
  cfra_pkg::out_t out_data_o;
  int             fail_count, pending;
  int             send_idle_pct, recv_idle_pct;

  contiguous_free_run_allocator uut (.*);

  cfra_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_request(logic [1:0] fn, int s, int e, int k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{func: fn, range_start: IDX_W'(s), range_end: IDX_W'(e),
                    run_length: LEN_W'(k)};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic random_request();
    int r, s, len;
    r   = $urandom_range(99);
    s   = $urandom_range(SLOTS - 1);
    len = ($urandom_range(9) == 0) ? $urandom_range(SLOTS) : $urandom_range(64);
    if (r < 35) send_request(cfra_pkg::FN_FIND, $urandom, $urandom, len);
    else if (r < 65) send_request(cfra_pkg::FN_USED, s,
                                  (s + len > SLOTS - 1) ? SLOTS - 1 : s + len, $urandom);
    else if (r < 93) send_request(cfra_pkg::FN_FREE, s,
                                  (s + len > SLOTS - 1) ? SLOTS - 1 : s + len, $urandom);
    else if (r < 97) send_request(2'($urandom_range(1, 2)), s, $urandom_range(SLOTS - 1),
                                  $urandom);
    else send_request(2'd3, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int spin;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 54;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(cfra_pkg::FN_FIND, 0, 0, SLOTS);
    send_request(cfra_pkg::FN_FIND, 0, 0, 0);
    send_request(cfra_pkg::FN_FIND, 1023, 1023, 1);
    send_request(cfra_pkg::FN_USED, 0, 0, 0);
    send_request(cfra_pkg::FN_FIND, 0, 0, 1);
    send_request(cfra_pkg::FN_FIND, 0, 0, SLOTS);
    send_request(cfra_pkg::FN_USED, 1023, 1023, 0);
    send_request(cfra_pkg::FN_USED, 300, 200, 0);
    send_request(cfra_pkg::FN_FREE, 5, 4, 0);
    send_request(cfra_pkg::FN_USED, 100, 499, 0);
    send_request(cfra_pkg::FN_FIND, 0, 0, 524);
    send_request(cfra_pkg::FN_FIND, 0, 0, 523);
    send_request(cfra_pkg::FN_FIND, 0, 0, 2047);
    send_request(2'd3, 1023, 0, 2047);
    send_request(cfra_pkg::FN_USED, 0, 1023, 0);
    send_request(cfra_pkg::FN_FIND, 0, 0, 1);
    send_request(cfra_pkg::FN_FREE, 511, 512, 0);
    send_request(cfra_pkg::FN_FIND, 0, 0, 2);
    send_request(cfra_pkg::FN_FREE, 0, 1023, 0);
    send_request(cfra_pkg::FN_FIND, 0, 0, 1024);

    for (int i = 0; i < 1100; i++) begin
      if (i == 370) begin
        send_idle_pct = 54;
        recv_idle_pct = 15;
      end else if (i == 740) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i % 100 == 50) begin
        spin = $urandom_range(40);
        while (spin-- > 0) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
        end
      end
      random_request();
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/cfra_pkg.sv
hdl/cfra_ram.sv
hdl/cfra_datapath.sv
hdl/cfra_ctrl.sv
hdl/contiguous_free_run_allocator.sv
tb/sv/cfra_checker.sv
tb/sv/tb_top.sv
